>>> rtl/stp_pkg.sv
// Shared types, constants and codes for the simplex tableau pivot block.
package stp_pkg;

  localparam int MaxRows  = 16;
  localparam int MaxCols  = 32;
  localparam int Stride   = MaxCols + 1;
  localparam int TabDepth = (MaxRows + 1) * Stride;
  localparam int AddrW    = $clog2(TabDepth);
  localparam int RowW     = 5;
  localparam int ColW     = 6;
  localparam int BasW     = 5;
  localparam int BrowW    = $clog2(MaxRows);

  localparam logic [2:0] REQ_WR_ENTRY = 3'd0;
  localparam logic [2:0] REQ_WR_BASIS = 3'd1;
  localparam logic [2:0] REQ_PIVOT    = 3'd2;
  localparam logic [2:0] REQ_RD_ENTRY = 3'd3;
  localparam logic [2:0] REQ_RD_BASIS = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_IDX  = 2'd2;
  localparam logic [1:0] ST_SAT  = 2'd3;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  // Divider command and status between the sequencer and the divide unit.
  typedef struct packed {
    logic        go;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic        sat;
    logic [31:0] quo;
  } div_rsp_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] v, output logic s);
    s = 1'b0;
    if (v > 64'sd2147483647) begin
      s = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -64'sd2147483648) begin
      s = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [AddrW-1:0] tab_addr(input logic [RowW-1:0] r,
                                                input logic [ColW-1:0] c);
    logic [AddrW-1:0] a;
    a = AddrW'(r) * AddrW'(Stride) + AddrW'(c);
    return a;
  endfunction

endpackage

>>> rtl/stp_div.sv
// Restoring divider: (num * 65536) / den, truncated toward zero, saturated.
module stp_div (
  input  logic            clk,
  input  logic            rst_n,
  input  stp_pkg::div_req_t req,
  output stp_pkg::div_rsp_t rsp
);
  import stp_pkg::*;

  logic [47:0] rem_r, rem_nxt;
  logic [47:0] quo_r, quo_nxt;
  logic [31:0] den_r, den_nxt;
  logic        neg_r, neg_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [48:0] trial;
  logic [47:0] nmag;
  logic [31:0] dmag;
  logic signed [63:0] sq;
  logic        s;
  logic [31:0] qv;

  always_comb begin
    nmag = req.num[31] ? 48'(-$signed({req.num[31], req.num})) : 48'(req.num);
    dmag = req.den[31] ? 32'(-req.den) : req.den;
    trial = {rem_r, quo_r[47]} - {17'd0, den_r};
    rem_nxt = rem_r; quo_nxt = quo_r; den_nxt = den_r; neg_nxt = neg_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    if (req.go) begin
      rem_nxt = '0;
      quo_nxt = {nmag[31:0], 16'd0};
      den_nxt = dmag;
      neg_nxt = req.num[31] ^ req.den[31];
      cnt_nxt = 6'd48;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // one quotient bit a cycle
      if (!trial[48]) rem_nxt = trial[47:0];
      else rem_nxt = {rem_r[46:0], quo_r[47]};
      quo_nxt = {quo_r[46:0], ~trial[48]};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  always_comb begin
    sq = neg_r ? -$signed({16'd0, quo_r}) : $signed({16'd0, quo_r});
    qv = sat32(sq, s);
    rsp.done = done_r;
    rsp.sat  = s;
    rsp.quo  = qv;
  end

  assert property (@(posedge clk) disable iff (!rst_n) rsp.done |-> !busy_r)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> cnt_r != 6'd0)
    else $error("divider busy with zero count");
  assert property (@(posedge clk) disable iff (!rst_n) rsp.done |=> !rsp.done)
    else $error("divider done held");

endmodule

>>> rtl/simplex_tableau_pivot.sv
// Top level of the simplex tableau pivot block: sequencer, tableau memory, basis.
//
// Use: raise start with req_type/row/col/value while busy is low; the item
// is taken at that edge and busy rises. One result comes back on the out_
// ports for one cycle, marked by out_valid; the receiver cannot stall it.
// Register writes go through cfg_valid/cfg_ready (cfg_index 0 row count,
// 1 column count); cfg_ready is always high, write only while idle.
// Path: writes, unknown types and rejected writes or pivots go S_CHECK then
// S_DONE; reads and a zero pivot also pass S_PRD and S_PTST. The next item
// can be taken at the edge that takes the result of the last one.
// A pivot on R rows and C columns first divides the C+1 entries of the pivot
// row, one 48-step divide per entry on the one divider, then updates the R
// other rows (objective row included) entry by entry over one memory port,
// each entry passing S_ERD, S_MUL and S_WB. One item is in work at a time.
// Reset: counts go to 16 and 32; the tableau and basis hold whatever was
// last written; the user must write them before reading, the block does not enforce it.
module simplex_tableau_pivot (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_req_type,
  input  logic [4:0]  in_row,
  input  logic [5:0]  in_col,
  input  logic signed [31:0] in_value,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic signed [31:0] out_read_value,
  output logic [4:0]  out_basis_col,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import stp_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_CHECK = 13'b0000000000010,
    S_PRD   = 13'b0000000000100,
    S_PTST  = 13'b0000000001000,
    S_DRD   = 13'b0000000010000,
    S_DGO   = 13'b0000000100000,
    S_DWT   = 13'b0000001000000,
    S_FRD   = 13'b0000010000000,
    S_FGET  = 13'b0000100000000,
    S_ERD   = 13'b0001000000000,
    S_MUL   = 13'b0010000000000,
    S_WB    = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0] tab_mem [TabDepth];
  logic [BasW-1:0] bas_mem [MaxRows];

  logic [RowW-1:0] rows_r;
  logic [ColW-1:0] cols_r;
  logic [RowW-1:0] nr, eff_rows;
  logic [ColW-1:0] nc, eff_cols;

  logic [2:0]  req_r;
  logic [RowW-1:0] row_r, row_nxt;
  logic [ColW-1:0] col_r;
  logic [31:0] val_r;
  logic [RowW-1:0] i_r, i_nxt;
  logic [ColW-1:0] j_r, j_nxt;
  logic [31:0] piv_r, piv_nxt;
  logic [31:0] f_r, f_nxt;
  logic [31:0] rd_q;
  logic [31:0] prow_r, prow_nxt;
  logic signed [63:0] prod_r;
  logic sat_r, sat_nxt;
  logic [1:0]  st_r, st_nxt;
  logic [31:0] rv_r, rv_nxt;
  logic [BasW-1:0] bc_r, bc_nxt;
  logic ov_r, ov_nxt;

  logic [AddrW-1:0] raddr;
  logic we;
  logic [AddrW-1:0] waddr;
  logic [31:0] wdata;
  logic bwe;
  logic [BrowW-1:0] bwaddr;
  logic [BasW-1:0] bwdata;
  logic [BasW-1:0] bas_q;

  div_req_t dreq;
  div_rsp_t drsp;
  logic signed [63:0] tdiff;
  logic signed [63:0] tsh;
  logic [31:0] upd;
  logic usat;

  stp_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // clamp the counts to legal ranges
  always_comb begin
    eff_rows = (rows_r == '0) ? RowW'(1) :
               (rows_r > RowW'(MaxRows)) ? RowW'(MaxRows) : rows_r;
    eff_cols = (cols_r == '0) ? ColW'(1) :
               (cols_r > ColW'(MaxCols)) ? ColW'(MaxCols) : cols_r;
    nr = eff_rows;
    nc = eff_cols;
  end

  assign cfg_ready = 1'b1;
  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= RowW'(16);
      cols_r <= ColW'(32);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_ROWS) rows_r <= cfg_data[RowW-1:0];
      else cols_r <= cfg_data[ColW-1:0];
    end
  end

  // memories: one write and one registered read port each
  always_ff @(posedge clk) begin
    if (we) tab_mem[waddr] <= wdata;
    rd_q <= tab_mem[raddr];
    if (bwe) bas_mem[bwaddr] <= bwdata;
    bas_q <= bas_mem[row_r[BrowW-1:0]];
  end

  // row update: e - (f*r)>>16 toward zero, saturated
  always_comb begin
    tsh = (prod_r < 0) ? -((-prod_r) >>> 16) : (prod_r >>> 16);
    tdiff = $signed({{32{rd_q[31]}}, rd_q}) - tsh;
    upd = sat32(tdiff, usat);
  end

  always_comb begin
    state_nxt = state_r;
    row_nxt = row_r; i_nxt = i_r; j_nxt = j_r;
    piv_nxt = piv_r; f_nxt = f_r; prow_nxt = prow_r;
    sat_nxt = sat_r; st_nxt = st_r; rv_nxt = rv_r; bc_nxt = bc_r;
    ov_nxt = 1'b0;
    raddr = tab_addr(row_r, col_r);
    we = 1'b0; waddr = tab_addr(row_r, col_r); wdata = val_r;
    bwe = 1'b0; bwaddr = row_r[BrowW-1:0]; bwdata = val_r[BasW-1:0];
    dreq.go = 1'b0; dreq.num = rd_q; dreq.den = piv_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        // issue the read of (row,col); the basis read follows row_r
        st_nxt = ST_IDX; rv_nxt = '0; bc_nxt = '0; sat_nxt = 1'b0;
        state_nxt = S_DONE;
        case (req_r)
          REQ_WR_ENTRY: begin
            if (row_r <= nr && col_r <= nc) begin
              we = 1'b1; st_nxt = ST_OK;
            end
          end
          REQ_WR_BASIS: begin
            if (row_r < nr && !val_r[31] && val_r < 32'(nc)) begin
              bwe = 1'b1; st_nxt = ST_OK;
            end
          end
          REQ_PIVOT: begin
            if (row_r < nr && col_r < nc) state_nxt = S_PRD;
          end
          REQ_RD_ENTRY, REQ_RD_BASIS: begin
            state_nxt = S_PRD;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_PRD: begin
        state_nxt = S_PTST;
      end
      S_PTST: begin
        state_nxt = S_DONE;
        if (req_r == REQ_RD_ENTRY) begin
          if (row_r <= nr && col_r <= nc) begin
            rv_nxt = rd_q; st_nxt = ST_OK;
            if (row_r < nr) bc_nxt = bas_q;
          end
        end else if (req_r == REQ_RD_BASIS) begin
          if (row_r < nr) begin
            bc_nxt = bas_q; st_nxt = ST_OK;
          end
        end else if (rd_q == '0) begin
          st_nxt = ST_ZERO;
        end else begin
          piv_nxt = rd_q; j_nxt = '0; state_nxt = S_DRD;
        end
      end
      S_DRD: begin
        raddr = tab_addr(row_r, j_r);
        state_nxt = S_DGO;
      end
      S_DGO: begin
        raddr = tab_addr(row_r, j_r);
        state_nxt = S_DWT;
      end
      S_DWT: begin
        if (drsp.done) begin
          we = 1'b1; waddr = tab_addr(row_r, j_r); wdata = drsp.quo;
          if (drsp.sat) sat_nxt = 1'b1;
          if (j_r == nc) begin
            i_nxt = '0; state_nxt = S_FRD;
          end else begin
            j_nxt = j_r + ColW'(1); state_nxt = S_DRD;
          end
        end
      end
      S_FRD: begin
        raddr = tab_addr(i_r, col_r);
        if (i_r == row_r) begin
          if (i_r == nr) state_nxt = S_DONE;
          else i_nxt = i_r + RowW'(1);
        end else state_nxt = S_FGET;
      end
      S_FGET: begin
        f_nxt = rd_q; j_nxt = '0;
        raddr = tab_addr(row_r, '0);
        state_nxt = S_ERD;
      end
      S_ERD: begin
        prow_nxt = rd_q;
        raddr = tab_addr(i_r, j_r);
        state_nxt = S_MUL;
      end
      S_MUL: begin
        raddr = tab_addr(i_r, j_r);
        state_nxt = S_WB;
      end
      S_WB: begin
        we = 1'b1; waddr = tab_addr(i_r, j_r); wdata = upd;
        if (usat) sat_nxt = 1'b1;
        if (j_r == nc) begin
          if (i_r == nr) begin
            // last entry written is the objective RHS: report it directly
            bwe = 1'b1; bwdata = col_r[BasW-1:0];
            bc_nxt = col_r[BasW-1:0];
            st_nxt = (sat_r || usat) ? ST_SAT : ST_OK;
            rv_nxt = upd;
            state_nxt = S_DONE;
          end else begin
            i_nxt = i_r + RowW'(1); state_nxt = S_FRD;
          end
        end else begin
          j_nxt = j_r + ColW'(1);
          raddr = tab_addr(row_r, j_r + ColW'(1));
          state_nxt = S_ERD;
        end
      end
      S_DONE: begin
        ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_DGO) dreq.go = 1'b1;
  end

  always_ff @(posedge clk) begin
    prod_r <= $signed(f_r) * $signed(prow_r);
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    if (state_r == S_IDLE && start) begin
      req_r <= in_req_type;
      row_r <= in_row;
      col_r <= in_col;
      val_r <= in_value;
    end else begin
      row_r <= row_nxt;
    end
    i_r <= i_nxt; j_r <= j_nxt; piv_r <= piv_nxt; f_r <= f_nxt;
    prow_r <= prow_nxt; sat_r <= sat_nxt; st_r <= st_nxt;
    rv_r <= rv_nxt; bc_r <= bc_nxt;
  end

  assign out_valid      = ov_r;
  assign out_status     = st_r;
  assign out_read_value = rv_r;
  assign out_basis_col  = bc_r;

  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !busy)
    else $error("result while busy");
  assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
    else $error("item not taken");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_ZERO) |-> out_read_value == '0)
    else $error("zero pivot with data");
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid)
    else $error("result repeated");

endmodule
